### hdl/hvdt_pkg.sv
package hvdt_pkg;

	localparam int BUCKET_DEPTH = 1024;
	localparam int BUCKET_AW    = 10;
	localparam int CFG_W        = 11;
	localparam int NAME_W       = 32;

	localparam logic [CFG_W-1:0] BUCKET_RESET = 11'd1024;

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_CLEARED = 2'd2;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_HASH,
		ST_HEAD,
		ST_HEADW,
		ST_LOOK,
		ST_CMP,
		ST_DONE
	} state_t;

endpackage

### hdl/hashed_vertex_degree_table.sv
// edge word: modulo of both endpoints at once, then per endpoint a read
// of the bucket head and a compare for each chain entry, plus a new-entry
// step when the vertex is new or dropped, then a load of the output register
// clear word: a sweep of the bucket memory, then the output register
// after reset the same sweep runs with no word accepted
// one word at a time; the output register frees the input while a result waits
module hashed_vertex_degree_table #(
	parameter int MAX_ENTRIES = 1024,
	parameter int DEGREE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [31:0] first_vertex,
	input  logic [31:0] second_vertex,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] first_degree,
	output logic [15:0] second_degree,
	output logic [15:0] largest_degree,
	output logic [10:0] stored_vertices
);

	localparam int LW = $clog2(MAX_ENTRIES + 1);
	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int DB = DEGREE_BITS;
	localparam int NW = hvdt_pkg::NAME_W;
	localparam int EW = NW + DB + LW;
	localparam int AW = hvdt_pkg::BUCKET_AW;

	hvdt_pkg::state_t state_q, state_d;

	logic [hvdt_pkg::CFG_W-1:0] bc_q, bc_eff;
	logic [NW-1:0]              name_a_q, name_b_q, cur_name;
	logic                       sel_q, sel_d;
	logic                       clr_cmd_q, clr_cmd_d;
	logic [AW-1:0]              clr_cnt_q;
	logic [LW-1:0]              count_q, count_d;
	logic [DB-1:0]              max_q, max_d;
	logic [LW-1:0]              link_q, link_d, head_q, head_d;
	logic [LW-1:0]              link1_q, link1_d, link2_q, link2_d;
	logic [DB-1:0]              deg1_q, deg1_d, deg2_q, deg2_d;

	logic                       mod_start, mod_done;
	logic [AW-1:0]              rem_a, rem_b, cur_bkt;

	logic                       bkt_we;
	logic [AW-1:0]              bkt_waddr;
	logic [LW-1:0]              bkt_wdata, bkt_rdata;

	logic                       ent_we;
	logic [IW-1:0]              ent_waddr, ent_raddr;
	logic [EW-1:0]              ent_wdata, ent_rdata;
	logic [NW-1:0]              rd_name;
	logic [DB-1:0]              rd_deg, new_deg;
	logic [LW-1:0]              rd_next, link_m1;

	logic                       in_acc, out_load;
	logic [1:0]                 st_o;
	logic [15:0]                d1_o, d2_o, mx_o;
	logic [10:0]                cnt_o;
	logic [DB+15:0]             d1_w, d2_w, mx_w;
	logic [LW+10:0]             cnt_w;

	logic                       out_valid_q;
	logic [1:0]                 status_q;
	logic [15:0]                first_q, second_q, largest_q;
	logic [10:0]                stored_q;

	hvdt_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.name_a  (first_vertex),
		.name_b  (second_vertex),
		.divisor (bc_eff),
		.done    (mod_done),
		.rem_a   (rem_a),
		.rem_b   (rem_b)
	);

	hvdt_ram #(.DEPTH(hvdt_pkg::BUCKET_DEPTH), .WIDTH(LW)) u_bkt_ram (
		.clk   (clk),
		.we    (bkt_we),
		.waddr (bkt_waddr),
		.wdata (bkt_wdata),
		.raddr (cur_bkt),
		.rdata (bkt_rdata)
	);

	hvdt_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(EW)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	always_comb begin
		if (bc_q == '0) begin
			bc_eff = 11'd1;
		end else if (bc_q > hvdt_pkg::BUCKET_RESET) begin
			bc_eff = hvdt_pkg::BUCKET_RESET;
		end else begin
			bc_eff = bc_q;
		end
	end

	assign cur_bkt  = sel_q ? rem_b : rem_a;
	assign cur_name = sel_q ? name_b_q : name_a_q;
	assign link_m1  = link_q - LW'(1);
	assign ent_raddr = link_m1[IW-1:0];
	assign rd_name  = ent_rdata[EW-1 -: NW];
	assign rd_deg   = ent_rdata[LW +: DB];
	assign rd_next  = ent_rdata[LW-1:0];
	assign new_deg  = (rd_deg == '1) ? rd_deg : rd_deg + DB'(1);

	assign in_stall = (state_q != hvdt_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		state_d   = state_q;
		sel_d     = sel_q;
		clr_cmd_d = clr_cmd_q;
		count_d   = count_q;
		max_d     = max_q;
		link_d    = link_q;
		head_d    = head_q;
		link1_d   = link1_q;
		link2_d   = link2_q;
		deg1_d    = deg1_q;
		deg2_d    = deg2_q;
		mod_start = 1'b0;
		bkt_we    = 1'b0;
		bkt_waddr = cur_bkt;
		bkt_wdata = count_q + LW'(1);
		ent_we    = 1'b0;
		ent_waddr = count_q[IW-1:0];
		ent_wdata = {cur_name, DB'(1), head_q};
		out_load  = 1'b0;
		case (state_q)
			hvdt_pkg::ST_CLR: begin
				bkt_we    = 1'b1;
				bkt_waddr = clr_cnt_q;
				bkt_wdata = '0;
				if (clr_cnt_q == '1) begin
					state_d = clr_cmd_q ? hvdt_pkg::ST_DONE : hvdt_pkg::ST_IDLE;
				end
			end
			hvdt_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (func == hvdt_pkg::FUNC_CLEAR) begin
						clr_cmd_d = 1'b1;
						count_d   = '0;
						max_d     = '0;
						state_d   = hvdt_pkg::ST_CLR;
					end else begin
						clr_cmd_d = 1'b0;
						mod_start = 1'b1;
						sel_d     = 1'b0;
						state_d   = hvdt_pkg::ST_HASH;
					end
				end
			end
			hvdt_pkg::ST_HASH: begin
				if (mod_done) begin
					state_d = hvdt_pkg::ST_HEAD;
				end
			end
			hvdt_pkg::ST_HEAD: begin
				state_d = hvdt_pkg::ST_HEADW;
			end
			hvdt_pkg::ST_HEADW: begin
				head_d  = bkt_rdata;
				link_d  = bkt_rdata;
				state_d = hvdt_pkg::ST_LOOK;
			end
			hvdt_pkg::ST_LOOK: begin
				if (link_q != '0) begin
					state_d = hvdt_pkg::ST_CMP;
				end else begin
					// new entry at the chain head, or dropped when full
					if (count_q < LW'(MAX_ENTRIES)) begin
						ent_we  = 1'b1;
						bkt_we  = 1'b1;
						count_d = count_q + LW'(1);
						if (max_q == '0) begin
							max_d = DB'(1);
						end
						if (sel_q) begin
							link2_d = count_q + LW'(1);
							deg2_d  = DB'(1);
						end else begin
							link1_d = count_q + LW'(1);
							deg1_d  = DB'(1);
						end
					end else begin
						if (sel_q) begin
							link2_d = '0;
							deg2_d  = '0;
						end else begin
							link1_d = '0;
							deg1_d  = '0;
						end
					end
					sel_d   = 1'b1;
					state_d = sel_q ? hvdt_pkg::ST_DONE : hvdt_pkg::ST_HEAD;
				end
			end
			hvdt_pkg::ST_CMP: begin
				if (rd_name == cur_name) begin
					ent_we    = 1'b1;
					ent_waddr = link_m1[IW-1:0];
					ent_wdata = {rd_name, new_deg, rd_next};
					if (new_deg > max_q) begin
						max_d = new_deg;
					end
					if (sel_q) begin
						link2_d = link_q;
						deg2_d  = new_deg;
					end else begin
						link1_d = link_q;
						deg1_d  = new_deg;
					end
					sel_d   = 1'b1;
					state_d = sel_q ? hvdt_pkg::ST_DONE : hvdt_pkg::ST_HEAD;
				end else begin
					link_d  = rd_next;
					state_d = hvdt_pkg::ST_LOOK;
				end
			end
			hvdt_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = hvdt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hvdt_pkg::ST_IDLE;
			end
		endcase
	end

	// self loop: both fields show the final degree
	always_comb begin
		d1_w  = {16'd0, (link1_q != '0 && link1_q == link2_q) ? deg2_q : deg1_q};
		d2_w  = {16'd0, deg2_q};
		mx_w  = {16'd0, max_q};
		cnt_w = {11'd0, count_q};
		if (clr_cmd_q) begin
			st_o  = hvdt_pkg::STATUS_CLEARED;
			d1_o  = '0;
			d2_o  = '0;
			mx_o  = '0;
			cnt_o = '0;
		end else begin
			st_o  = (link1_q == '0 || link2_q == '0) ? hvdt_pkg::STATUS_FULL
			                                         : hvdt_pkg::STATUS_OK;
			d1_o  = d1_w[15:0];
			d2_o  = d2_w[15:0];
			mx_o  = mx_w[15:0];
			cnt_o = cnt_w[10:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hvdt_pkg::ST_CLR;
			clr_cmd_q   <= 1'b0;
			clr_cnt_q   <= '0;
			bc_q        <= hvdt_pkg::BUCKET_RESET;
			count_q     <= '0;
			max_q       <= '0;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_cmd_q <= clr_cmd_d;
			sel_q     <= sel_d;
			count_q   <= count_d;
			max_q     <= max_d;
			if (state_q == hvdt_pkg::ST_CLR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end else begin
				clr_cnt_q <= '0;
			end
			if (cfg_wr_en) begin
				bc_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			name_a_q <= first_vertex;
			name_b_q <= second_vertex;
		end
		link_q  <= link_d;
		head_q  <= head_d;
		link1_q <= link1_d;
		link2_q <= link2_d;
		deg1_q  <= deg1_d;
		deg2_q  <= deg2_d;
		if (out_load) begin
			status_q  <= st_o;
			first_q   <= d1_o;
			second_q  <= d2_o;
			largest_q <= mx_o;
			stored_q  <= cnt_o;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign first_degree    = first_q;
	assign second_degree   = second_q;
	assign largest_degree  = largest_q;
	assign stored_vertices = stored_q;

endmodule

### hdl/hvdt_ram.sv
module hvdt_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/hvdt_mod.sv
module hvdt_mod (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [hvdt_pkg::NAME_W-1:0]         name_a,
	input  logic [hvdt_pkg::NAME_W-1:0]         name_b,
	input  logic [hvdt_pkg::CFG_W-1:0]          divisor,
	output logic                                done,
	output logic [hvdt_pkg::BUCKET_AW-1:0]      rem_a,
	output logic [hvdt_pkg::BUCKET_AW-1:0]      rem_b
);

	logic                              busy_q;
	logic                              done_q;
	logic [4:0]                        cnt_q;
	logic [hvdt_pkg::NAME_W-1:0]       sa_q, sb_q;
	logic [hvdt_pkg::CFG_W-1:0]        ra_q, rb_q, div_q;
	logic [hvdt_pkg::CFG_W:0]          ta, tb;
	logic [hvdt_pkg::CFG_W-1:0]        ra_d, rb_d;

	// one restoring step per cycle on both names at once
	always_comb begin
		ta = {ra_q, sa_q[hvdt_pkg::NAME_W-1]};
		tb = {rb_q, sb_q[hvdt_pkg::NAME_W-1]};
		if (ta >= {1'b0, div_q}) begin
			ta = ta - {1'b0, div_q};
		end
		if (tb >= {1'b0, div_q}) begin
			tb = tb - {1'b0, div_q};
		end
		ra_d = ta[hvdt_pkg::CFG_W-1:0];
		rb_d = tb[hvdt_pkg::CFG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sa_q  <= name_a;
			sb_q  <= name_b;
			ra_q  <= '0;
			rb_q  <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			sa_q <= sa_q << 1;
			sb_q <= sb_q << 1;
			ra_q <= ra_d;
			rb_q <= rb_d;
		end
	end

	assign done  = done_q;
	assign rem_a = ra_q[hvdt_pkg::BUCKET_AW-1:0];
	assign rem_b = rb_q[hvdt_pkg::BUCKET_AW-1:0];

endmodule

### bench/tb_hashed_vertex_degree_table.sv
`default_nettype none

module tb_hashed_vertex_degree_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ENTRIES = 1024;
	localparam int DEGREE_BITS = 16;
	localparam logic [DEGREE_BITS-1:0] DEGREE_SAT = '1;
	localparam int IDLE_LIMIT  = 20000;

	typedef struct {
		logic                        op;
		logic [hvdt_pkg::NAME_W-1:0] va;
		logic [hvdt_pkg::NAME_W-1:0] vb;
	} edge_word_t;

	typedef struct {
		logic [1:0]  st;
		logic [15:0] deg_a;
		logic [15:0] deg_b;
		logic [15:0] deg_max;
		logic [10:0] count;
	} degree_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [10:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        func = hvdt_pkg::FUNC_ADD;
	logic [31:0] first_vertex = '0;
	logic [31:0] second_vertex = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [15:0] first_degree;
	logic [15:0] second_degree;
	logic [15:0] largest_degree;
	logic [10:0] stored_vertices;

	hashed_vertex_degree_table #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.DEGREE_BITS(DEGREE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.first_vertex(first_vertex),
		.second_vertex(second_vertex),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.first_degree(first_degree),
		.second_degree(second_degree),
		.largest_degree(largest_degree),
		.stored_vertices(stored_vertices)
	);

	always #5 clk = ~clk;

	// shadow copy of the table
	int                          heads [hvdt_pkg::BUCKET_DEPTH];
	logic [hvdt_pkg::NAME_W-1:0] names [MAX_ENTRIES];
	logic [DEGREE_BITS-1:0]      degrees [MAX_ENTRIES];
	int                          links [MAX_ENTRIES];
	int                          used_entries;
	logic [DEGREE_BITS-1:0]      peak_degree;
	logic [hvdt_pkg::CFG_W-1:0]  buckets_cfg;

	edge_word_t     pending_words [$];
	degree_report_t expected_reports [$];
	int  mismatches;
	bit  word_taken;
	int  burst_left, gap_left, stall_mode, stall_left, idle_cycles;

	function automatic void clear_shadow();
		for (int i = 0; i < hvdt_pkg::BUCKET_DEPTH; i++) heads[i] = 0;
		used_entries = 0;
		peak_degree = '0;
	endfunction

	// returns entry index plus one, or 0 when the vertex was dropped
	function automatic int bump_vertex(logic [hvdt_pkg::NAME_W-1:0] name);
		int eff, bkt, link, steps, idx;
		eff = (buckets_cfg == 0) ? 1 : ((buckets_cfg > hvdt_pkg::BUCKET_DEPTH) ?
			hvdt_pkg::BUCKET_DEPTH : int'(buckets_cfg));
		bkt = int'(name % eff);
		link = heads[bkt];
		steps = 0;
		while (link != 0 && steps <= used_entries) begin
			idx = link - 1;
			if (idx >= MAX_ENTRIES) begin
				link = 0;
				break;
			end
			if (names[idx] == name) break;
			link = links[idx];
			steps++;
		end
		if (steps > used_entries) link = 0;
		if (link != 0) begin
			idx = link - 1;
			if (degrees[idx] < DEGREE_SAT) degrees[idx]++;
			if (degrees[idx] > peak_degree) peak_degree = degrees[idx];
			return link;
		end
		if (used_entries >= MAX_ENTRIES) return 0;
		idx = used_entries;
		names[idx] = name;
		degrees[idx] = 1;
		links[idx] = heads[bkt];
		heads[bkt] = idx + 1;
		used_entries++;
		if (peak_degree < 1) peak_degree = 1;
		return idx + 1;
	endfunction

	function automatic degree_report_t apply_word(edge_word_t w);
		degree_report_t r;
		int la, lb;
		r = '{hvdt_pkg::STATUS_CLEARED, 16'd0, 16'd0, 16'd0, 11'd0};
		if (w.op == hvdt_pkg::FUNC_CLEAR) begin
			clear_shadow();
			return r;
		end
		la = bump_vertex(w.va);
		lb = bump_vertex(w.vb);
		r.st = (la == 0 || lb == 0) ? hvdt_pkg::STATUS_FULL : hvdt_pkg::STATUS_OK;
		r.deg_a = (la != 0) ? 16'(degrees[la-1]) : 16'd0;
		r.deg_b = (lb != 0) ? 16'(degrees[lb-1]) : 16'd0;
		r.deg_max = 16'(peak_degree);
		r.count = 11'(used_entries);
		return r;
	endfunction

	task automatic push_word(logic op, logic [31:0] a, logic [31:0] b);
		pending_words.push_back('{op, a, b});
	endtask

	task automatic wait_drained();
		wait (pending_words.size() == 0 && expected_reports.size() == 0 && !in_valid);
		repeat (5) @(negedge clk);
	endtask

	task automatic write_buckets(logic [hvdt_pkg::CFG_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		buckets_cfg = value;
	endtask

	// input and output sampling at the rising edge
	always @(posedge clk) begin
		degree_report_t want;
		word_taken = 1'b0;
		if (arst_n && in_valid && !in_stall) begin
			expected_reports.push_back(apply_word('{func, first_vertex, second_vertex}));
			word_taken = 1'b1;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
			end else begin
				want = expected_reports.pop_front();
				if (status !== want.st || first_degree !== want.deg_a ||
				    second_degree !== want.deg_b || largest_degree !== want.deg_max ||
				    stored_vertices !== want.count) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at %0t: exp st=%0d a=%0d b=%0d max=%0d n=%0d",
							$realtime, want.st, want.deg_a, want.deg_b,
							want.deg_max, want.count);
						$display("  got st=%0d a=%0d b=%0d max=%0d n=%0d",
							status, first_degree, second_degree,
							largest_degree, stored_vertices);
					end
				end
			end
		end
		if (word_taken || (out_valid && !out_stall) ||
		    (pending_words.size() == 0 && expected_reports.size() == 0 && !in_valid))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// sender: bursts with random gaps
	always @(negedge clk) begin
		edge_word_t w;
		if (arst_n && (!in_valid || word_taken)) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 20);
				gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				w = pending_words.pop_front();
				func <= w.op;
				first_vertex <= w.va;
				second_vertex <= w.vb;
				in_valid <= 1'b1;
				burst_left--;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(50, 300);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			default: out_stall <= ((stall_left % 24) < 12);
		endcase
	end

	initial begin
		logic [31:0] pool [24];
		logic [hvdt_pkg::CFG_W-1:0] chunk_cfg [5];
		logic [31:0] a, b;
		mismatches = 0;
		burst_left = 0;
		gap_left = 0;
		stall_left = 0;
		idle_cycles = 0;
		buckets_cfg = hvdt_pkg::BUCKET_RESET;
		clear_shadow();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words at the reset bucket count
		push_word(hvdt_pkg::FUNC_ADD, 32'h0, 32'h0);
		push_word(hvdt_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'h0);
		push_word(hvdt_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_word(hvdt_pkg::FUNC_ADD, 32'hAAAA_AAAA, 32'h5555_5555);
		push_word(hvdt_pkg::FUNC_ADD, 32'd1024, 32'd0);
		push_word(hvdt_pkg::FUNC_ADD, 32'd2048, 32'd1024);
		push_word(hvdt_pkg::FUNC_ADD, 32'h5555_5555, 32'hAAAA_AAAA);
		push_word(hvdt_pkg::FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_word(hvdt_pkg::FUNC_ADD, 32'd0, 32'd1024);
		// one bucket: every vertex in a single chain
		write_buckets(11'd1);
		push_word(hvdt_pkg::FUNC_CLEAR, 32'h0, 32'h0);
		for (int i = 0; i < 6; i++) push_word(hvdt_pkg::FUNC_ADD, 32'(i), 32'(5 - i));
		// count changed with entries present: old entries may be missed
		write_buckets(11'd0);
		push_word(hvdt_pkg::FUNC_ADD, 32'd3, 32'd4);
		write_buckets(11'd2047);
		push_word(hvdt_pkg::FUNC_ADD, 32'd3, 32'd1027);
		write_buckets(11'd7);
		push_word(hvdt_pkg::FUNC_ADD, 32'd3, 32'd10);

		// fill the table past its capacity
		write_buckets(11'd1024);
		push_word(hvdt_pkg::FUNC_CLEAR, 32'h0, 32'h0);
		for (int k = 0; k < 515; k++)
			push_word(hvdt_pkg::FUNC_ADD, 32'hA000_0000 + 2 * k, 32'hA000_0001 + 2 * k);
		for (int k = 0; k < 10; k++)
			push_word(hvdt_pkg::FUNC_ADD, 32'hA000_0000 + k, 32'hB000_0000 + k);

		// random part over several bucket counts
		chunk_cfg = '{11'd1024, 11'd0, 11'd2047, 11'd1, 11'($urandom_range(2, 1023))};
		for (int c = 0; c < 5; c++) begin
			write_buckets(chunk_cfg[c]);
			push_word(hvdt_pkg::FUNC_CLEAR, $urandom, $urandom);
			for (int i = 0; i < 24; i++)
				pool[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom;
			pool[0] = 32'h0;
			pool[1] = 32'hFFFF_FFFF;
			for (int i = 0; i < 20; i++) begin
				a = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 23)] : $urandom;
				b = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 23)] : $urandom;
				if ($urandom_range(0, 9) == 0) b = a;
				push_word(($urandom_range(0, 99) < 4) ? hvdt_pkg::FUNC_CLEAR
				                                      : hvdt_pkg::FUNC_ADD, a, b);
			end
		end

		// self loops on one vertex
		write_buckets(11'd3);
		push_word(hvdt_pkg::FUNC_CLEAR, 32'h0, 32'h0);
		for (int i = 0; i < 2; i++)
			push_word(hvdt_pkg::FUNC_ADD, 32'h1234_5678, 32'h1234_5678);
		push_word(hvdt_pkg::FUNC_ADD, 32'h1234_5678, 32'h0);

		wait (pending_words.size() == 0 && expected_reports.size() == 0 && !in_valid);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_reports.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
